// ===== rtl/fifo_task_lock_arbiter_macros.svh =====
// assertion helpers shared by the checker
`ifndef FIFO_TASK_LOCK_ARBITER_MACROS_SVH
`define FIFO_TASK_LOCK_ARBITER_MACROS_SVH

// property checked only outside reset
`define FTLA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define FTLA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ftla_pkg.sv =====
package ftla_pkg;

  // requester identifier width
  localparam int ID_W = 4;

  // default number of requesters and queue cells
  localparam int REQUESTERS_DEF = 16;

  // action codes
  localparam logic [1:0] ACT_ACQUIRE = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_UP      = 2'd2;
  localparam logic [1:0] ACT_DOWN    = 2'd3;

  // control common to every queue cell
  typedef struct packed {
    logic            shift;
    logic [ID_W-1:0] id;
  } ftla_cell_ctl_t;

endpackage

// ===== rtl/ftla_if.sv =====
interface ftla_req_if;
  import ftla_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      action;
  logic [ID_W-1:0] requester;

  modport source (output valid, output action, output requester, input ready);
  modport sink   (input valid, input action, input requester, output ready);
endinterface

interface ftla_res_if;
  import ftla_pkg::*;

  logic            valid;
  logic            ready;
  logic            granted;
  logic            handoff_valid;
  logic [ID_W-1:0] handoff_id;

  modport source (output valid, output granted, output handoff_valid, output handoff_id,
                  input ready);
  modport sink   (input valid, input granted, input handoff_valid, input handoff_id,
                  output ready);
endinterface

// ===== rtl/ftla_cell.sv =====
module ftla_cell (
  input  logic                       clk,
  input  ftla_pkg::ftla_cell_ctl_t   ctl,
  input  logic                       load,
  input  logic [ftla_pkg::ID_W-1:0]  from_next,
  output logic [ftla_pkg::ID_W-1:0]  data
);
  import ftla_pkg::*;

  // one queue slot: move toward the head on dequeue, take the new id when it is the tail
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data <= from_next;
    end else if (load) begin
      data <= ctl.id;
    end
  end

endmodule

// ===== rtl/fifo_task_lock_arbiter.sv =====
// fifo-ordered lock with a shifting wait queue of REQUESTERS cells
// accepted item: result, owner, bitmap and queue cells all register in the next cycle
// throughput: 1 item per cycle while no result is stalled by res.ready
// reset (rst, synchronous): offline, no owner, empty queue, bitmap clear, no result pending
// queue cell contents are not cleared; the fill count marks which cells hold waiters
module fifo_task_lock_arbiter #(
  parameter int REQUESTERS = ftla_pkg::REQUESTERS_DEF
) (
  input logic       clk,
  input logic       rst,
  ftla_req_if.sink  req,
  ftla_res_if.source res
);
  import ftla_pkg::*;

  localparam int CNT_W  = $clog2(REQUESTERS + 1);
  localparam int MASK_W = (REQUESTERS < (1 << ID_W)) ? REQUESTERS : (1 << ID_W);

  logic              online, online_next;
  logic              owner_valid, owner_valid_next;
  logic [ID_W-1:0]   owner_id, owner_id_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [MASK_W-1:0] mask, mask_next;

  logic              granted_c, hvalid_c;
  logic [ID_W-1:0]   hid_c;
  logic              enq;
  logic              fire;
  logic              id_ok;
  logic              is_waiting;
  logic              q_full;
  logic [ID_W-1:0]   head;
  ftla_cell_ctl_t    ctl;

  logic [ID_W-1:0]   cell_data [REQUESTERS];

  // output register frees as soon as its item is taken
  assign req.ready = !res.valid || res.ready;
  assign fire      = req.valid && req.ready;

  assign id_ok  = 32'(req.requester) < REQUESTERS;
  assign q_full = count == CNT_W'(REQUESTERS);
  assign head   = cell_data[0];

  // bitmap lookup for the requester
  always_comb begin
    is_waiting = 1'b0;
    for (int k = 0; k < MASK_W; k++) begin
      if (req.requester == ID_W'(k) && mask[k]) begin
        is_waiting = 1'b1;
      end
    end
  end

  // lock state update and result
  always_comb begin
    online_next      = online;
    owner_valid_next = owner_valid;
    owner_id_next    = owner_id;
    count_next       = count;
    mask_next        = mask;
    granted_c        = 1'b0;
    hvalid_c         = 1'b0;
    hid_c            = '0;
    enq              = 1'b0;
    ctl.shift        = 1'b0;
    ctl.id           = req.requester;
    if (fire) begin
      case (req.action)
        ACT_ACQUIRE: begin
          if (online && id_ok) begin
            if (!owner_valid) begin
              owner_valid_next = 1'b1;
              owner_id_next    = req.requester;
              granted_c        = 1'b1;
            end else if (owner_id == req.requester) begin
              granted_c = 1'b1;
            end else if (!is_waiting && !q_full) begin
              enq        = 1'b1;
              count_next = count + CNT_W'(1);
              for (int k = 0; k < MASK_W; k++) begin
                if (req.requester == ID_W'(k)) begin
                  mask_next[k] = 1'b1;
                end
              end
            end
          end
        end
        ACT_RELEASE: begin
          if (online && id_ok && owner_valid && owner_id == req.requester) begin
            if (count != '0) begin
              ctl.shift     = 1'b1;
              count_next    = count - CNT_W'(1);
              owner_id_next = head;
              hvalid_c      = 1'b1;
              hid_c         = head;
              for (int k = 0; k < MASK_W; k++) begin
                if (head == ID_W'(k)) begin
                  mask_next[k] = 1'b0;
                end
              end
            end else begin
              owner_valid_next = 1'b0;
              owner_id_next    = '0;
            end
          end
        end
        ACT_UP: begin
          online_next = 1'b1;
        end
        ACT_DOWN: begin
          online_next      = 1'b0;
          owner_valid_next = 1'b0;
          owner_id_next    = '0;
          count_next       = '0;
          mask_next        = '0;
        end
        default: begin
          online_next = online;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      online      <= 1'b0;
      owner_valid <= 1'b0;
      owner_id    <= '0;
      count       <= '0;
      mask        <= '0;
      res.valid   <= 1'b0;
    end else begin
      online      <= online_next;
      owner_valid <= owner_valid_next;
      owner_id    <= owner_id_next;
      count       <= count_next;
      mask        <= mask_next;
      if (fire) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res.granted       <= granted_c;
      res.handoff_valid <= hvalid_c;
      res.handoff_id    <= hid_c;
    end
  end

  // wait queue: a row of cells, head at cell 0, tail at the fill count
  for (genvar i = 0; i < REQUESTERS; i++) begin : g_cell
    logic [ID_W-1:0] nbr;
    logic            load;
    if (i == REQUESTERS - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end
    assign load = enq && (count == CNT_W'(i));
    ftla_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load      (load),
      .from_next (nbr),
      .data      (cell_data[i])
    );
  end

endmodule

// ===== rtl/ftla_checker.sv =====
`include "fifo_task_lock_arbiter_macros.svh"

module ftla_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic [1:0]                req_action,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic                      res_granted,
  input logic                      res_handoff_valid,
  input logic [ftla_pkg::ID_W-1:0] res_handoff_id
);
  import ftla_pkg::*;

  logic req_fire;
  assign req_fire = req_valid && req_ready;

  // no result may be pending right after reset
  `FTLA_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid, "result pending after reset")

  // every accepted item shows a result on the next cycle
  `FTLA_ASSERT(a_item_result, req_fire |=> res_valid, "accepted item gave no result")

  // a grant and a handoff never come from the same item
  `FTLA_ASSERT(a_grant_xor_handoff, res_valid |-> !(res_granted && res_handoff_valid),
    "grant and handoff in one result")

  // a layer action (up or down) neither grants nor hands off, and its handoff id is zero
  `FTLA_ASSERT(a_action_result,
    req_fire && (req_action == ACT_UP || req_action == ACT_DOWN) |=>
      !res_granted && !res_handoff_valid && res_handoff_id == '0,
    "layer action gave a nonzero result")

  // a stalled result holds its payload
  `FTLA_ASSERT(a_res_hold,
    res_valid && !res_ready |=> res_valid && $stable(res_granted) &&
      $stable(res_handoff_valid) && $stable(res_handoff_id),
    "stalled result changed")

endmodule

bind fifo_task_lock_arbiter ftla_checker u_ftla_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .req_action        (req.action),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_granted       (res.granted),
  .res_handoff_valid (res.handoff_valid),
  .res_handoff_id    (res.handoff_id)
);

// ===== tb/sv/fifo_task_lock_arbiter_tb.sv =====
`timescale 1ns / 1ps
module fifo_task_lock_arbiter_tb;
  import ftla_pkg::*;

  localparam int NUM_REQ      = REQUESTERS_DEF;
  localparam int RANDOM_ITEMS = 1730;
  localparam int HOLD_START   = 600;
  localparam int HOLD_CYCLES  = 300;

  // one expected lock result
  typedef struct packed {
    logic            granted;
    logic            handoff_valid;
    logic [ID_W-1:0] handoff_id;
  } lock_result_t;

  // tracks lock ownership and the wait queue, holds expected results in order
  class lock_scoreboard;
    bit                  online;
    bit                  owner_valid;
    logic [ID_W-1:0]     owner_id;
    logic [ID_W-1:0]     waiters[$];
    logic [NUM_REQ-1:0]  waiting_mask;
    lock_result_t        pending[$];
    int                  errors;

    function new();
      online       = 1'b0;
      owner_valid  = 1'b0;
      owner_id     = '0;
      waiting_mask = '0;
      errors       = 0;
    endfunction

    // update lock state for an accepted item and queue its result
    function void note_request(logic [1:0] action, logic [ID_W-1:0] requester);
      lock_result_t r;
      bit id_ok;
      r     = '0;
      id_ok = (int'(requester) < NUM_REQ);
      case (action)
        ACT_ACQUIRE: begin
          if (online && id_ok) begin
            if (!owner_valid) begin
              owner_valid = 1'b1;
              owner_id    = requester;
              r.granted   = 1'b1;
            end else if (owner_id == requester) begin
              r.granted = 1'b1;
            end else if (!waiting_mask[requester] && waiters.size() < NUM_REQ) begin
              waiters.insert(waiters.size(), requester);
              waiting_mask[requester] = 1'b1;
            end
          end
        end
        ACT_RELEASE: begin
          if (online && id_ok && owner_valid && owner_id == requester) begin
            owner_valid = 1'b0;
            owner_id    = '0;
            if (waiters.size() > 0) begin
              owner_id                 = waiters[0];
              waiters.delete(0);
              owner_valid              = 1'b1;
              waiting_mask[owner_id]   = 1'b0;
              r.handoff_valid          = 1'b1;
              r.handoff_id             = owner_id;
            end
          end
        end
        ACT_UP: begin
          online = 1'b1;
        end
        default: begin
          online       = 1'b0;
          owner_valid  = 1'b0;
          owner_id     = '0;
          waiters.delete();
          waiting_mask = '0;
        end
      endcase
      pending.insert(pending.size(), r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // compare one accepted result with the oldest expectation
    task check_result(logic granted, logic handoff_valid, logic [ID_W-1:0] handoff_id);
      lock_result_t e;
      if (pending.size() == 0) begin
        report("result with no item outstanding");
      end else begin
        e = pending[0];
        pending.delete(0);
        if (granted !== e.granted)
          report($sformatf("granted got %b exp %b", granted, e.granted));
        if (handoff_valid !== e.handoff_valid)
          report($sformatf("handoff_valid got %b exp %b", handoff_valid, e.handoff_valid));
        if (handoff_id !== e.handoff_id)
          report($sformatf("handoff_id got %0d exp %0d", handoff_id, e.handoff_id));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  ftla_req_if req_ch();
  ftla_res_if res_ch();

  lock_scoreboard sb;
  int  items_sent;
  bit  hold_off;

  fifo_task_lock_arbiter #(.REQUESTERS(NUM_REQ)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // offer one item and wait for its acceptance
  task send_item(logic [1:0] action, logic [ID_W-1:0] requester);
    int gap;
    gap = hold_off ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= action;
    req_ch.requester <= requester;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(action, requester);
    items_sent++;
  endtask

  // fixed sequence over offline, grant, regrant, queueing, handoff and layer changes
  task run_directed();
    send_item(ACT_ACQUIRE, 4'd0);
    send_item(ACT_RELEASE, 4'd0);
    send_item(ACT_DOWN, 4'd15);
    send_item(ACT_UP, 4'd0);
    send_item(ACT_UP, 4'd15);
    send_item(ACT_ACQUIRE, 4'd0);
    send_item(ACT_ACQUIRE, 4'd0);
    send_item(ACT_ACQUIRE, 4'd15);
    send_item(ACT_ACQUIRE, 4'd15);
    send_item(ACT_ACQUIRE, 4'd5);
    send_item(ACT_RELEASE, 4'd15);
    send_item(ACT_RELEASE, 4'd0);
    send_item(ACT_RELEASE, 4'd15);
    send_item(ACT_RELEASE, 4'd5);
    send_item(ACT_RELEASE, 4'd5);
    send_item(ACT_ACQUIRE, 4'd10);
    send_item(ACT_ACQUIRE, 4'd3);
    send_item(ACT_DOWN, 4'd0);
    send_item(ACT_ACQUIRE, 4'd3);
    send_item(ACT_UP, 4'd3);
    send_item(ACT_ACQUIRE, 4'd3);
    send_item(ACT_RELEASE, 4'd3);
  endtask

  // episodes biased toward filling or draining the queue, with noise mixed in
  task run_random();
    int mode;
    int left;
    int p;
    logic [1:0]      action;
    logic [ID_W-1:0] requester;
    left = 0;
    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (left == 0) begin
        mode = $urandom_range(2);
        left = $urandom_range(80, 20);
      end
      left--;
      p         = $urandom_range(99);
      requester = ID_W'($urandom_range(NUM_REQ - 1));
      if (!sb.online) begin
        if (p < 70)      action = ACT_UP;
        else if (p < 85) action = ACT_ACQUIRE;
        else if (p < 95) action = ACT_RELEASE;
        else             action = ACT_DOWN;
      end else if (p < 2) begin
        action = ACT_DOWN;
      end else if (p < 4) begin
        action = ACT_UP;
      end else begin
        p = $urandom_range(99);
        case (mode)
          0:       action = (p < 85) ? ACT_ACQUIRE : ACT_RELEASE;
          1:       action = (p < 20) ? ACT_ACQUIRE : ACT_RELEASE;
          default: action = (p < 55) ? ACT_ACQUIRE : ACT_RELEASE;
        endcase
        // releases mostly come from the current owner so handoffs happen
        if (action == ACT_RELEASE && sb.owner_valid && $urandom_range(99) < 80)
          requester = sb.owner_id;
      end
      send_item(action, requester);
    end
  endtask

  // receiver: random stalls plus the long hold-off
  initial begin
    int stall;
    int p;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else begin
        if (res_ch.valid && res_ch.ready)
          sb.check_result(res_ch.granted, res_ch.handoff_valid, res_ch.handoff_id);
        if (hold_off) begin
          res_ch.ready <= 1'b0;
        end else if (stall > 0) begin
          stall--;
          res_ch.ready <= 1'b0;
        end else begin
          p = $urandom_range(99);
          if (p < 70) begin
            res_ch.ready <= 1'b1;
          end else begin
            if (p < 92)      stall = $urandom_range(3, 1);
            else if (p < 98) stall = $urandom_range(10, 4);
            else             stall = $urandom_range(60, 20);
            stall--;
            res_ch.ready <= 1'b0;
          end
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    hold_off = 1'b0;
    wait (items_sent >= HOLD_START);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // main stimulus and end of run
  initial begin
    sb               = new();
    items_sent       = 0;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.action    = ACT_ACQUIRE;
    req_ch.requester = '0;
    res_ch.ready     = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    req_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // run limit
  initial begin
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
